FILE: design/bpst_pkg.sv
// Shared constants for the box versus plane side test.
`timescale 1ns / 1ps
package bpst_pkg;

   // Number of axes of a box and a plane normal
   localparam int AXES = 3;

   // Width of the side classification
   localparam int SIDE_BITS = 2;

   // Bit positions of the side classification
   localparam int SIDE_FRONT = 0;
   localparam int SIDE_BACK  = 1;

   // Width of the register index on the configuration port
   localparam int CSR_INDEX_BITS = 3;

   // Register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NORMAL_X     = 3'd0,
      CSR_NORMAL_Y     = 3'd1,
      CSR_NORMAL_Z     = 3'd2,
      CSR_PLANE_OFFSET = 3'd3,
      CSR_SIGN_MASK    = 3'd4
   } csr_index_type;

endpackage

FILE: design/bpst_csr.sv
// Plane configuration registers: normal, offset and corner sign mask.
`timescale 1ns / 1ps
module bpst_csr #(
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic [bpst_pkg::CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [COORD_BITS+NORMAL_FRAC_BITS+3:0]          csr_data,
   output logic signed [NORMAL_FRAC_BITS+1:0]              normal [bpst_pkg::AXES],
   output logic signed [COORD_BITS+NORMAL_FRAC_BITS+3:0]   plane_offset,
   output logic [bpst_pkg::AXES-1:0]                       sign_mask
);
   import bpst_pkg::*;

   localparam int NB = NORMAL_FRAC_BITS + 2;
   localparam int OB = COORD_BITS + NORMAL_FRAC_BITS + 4;

   logic signed [NB-1:0]  normal_ff [AXES];
   logic signed [NB-1:0]  normal_in [AXES];
   logic signed [OB-1:0]  offset_ff, offset_in;
   logic [AXES-1:0]       mask_ff, mask_in;
   logic                  write_en;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   // Decode the register index; drop writes beyond the map
   always_comb begin
      normal_in = normal_ff;
      offset_in = offset_ff;
      mask_in   = mask_ff;
      if (write_en) begin
         unique case (csr_index)
            CSR_NORMAL_X:     normal_in[0] = signed'(csr_data[NB-1:0]);
            CSR_NORMAL_Y:     normal_in[1] = signed'(csr_data[NB-1:0]);
            CSR_NORMAL_Z:     normal_in[2] = signed'(csr_data[NB-1:0]);
            CSR_PLANE_OFFSET: offset_in    = signed'(csr_data[OB-1:0]);
            CSR_SIGN_MASK:    mask_in      = csr_data[AXES-1:0];
            default:          ;
         endcase
      end
   end

   // Hold the plane; reset to the unit z normal through the origin
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NB'(1) << NORMAL_FRAC_BITS;
         offset_ff    <= '0;
         mask_ff      <= '0;
      end else begin
         normal_ff <= normal_in;
         offset_ff <= offset_in;
         mask_ff   <= mask_in;
      end
   end

   assign normal       = normal_ff;
   assign plane_offset = offset_ff;
   assign sign_mask    = mask_ff;

endmodule

FILE: design/bpst_dot.sv
// Four-stage datapath: corner select, multiply, sum, compare against the plane.
`timescale 1ns / 1ps
module bpst_dot #(
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  logic signed [COORD_BITS-1:0]                    box_lo [bpst_pkg::AXES],
   input  logic signed [COORD_BITS-1:0]                    box_hi [bpst_pkg::AXES],
   input  logic signed [NORMAL_FRAC_BITS+1:0]              normal [bpst_pkg::AXES],
   input  logic signed [COORD_BITS+NORMAL_FRAC_BITS+3:0]   plane_offset,
   input  logic [bpst_pkg::AXES-1:0]                       sign_mask,
   output logic                                            out_valid,
   output logic [bpst_pkg::SIDE_BITS-1:0]                  out_sides
);
   import bpst_pkg::*;

   localparam int NB = NORMAL_FRAC_BITS + 2;
   localparam int PB = COORD_BITS + NB;
   localparam int OB = COORD_BITS + NORMAL_FRAC_BITS + 4;

   // Stage 1: chosen corners
   logic                         v1_ff;
   logic signed [COORD_BITS-1:0] far_c_ff [AXES], far_c_in [AXES];
   logic signed [COORD_BITS-1:0] near_c_ff [AXES], near_c_in [AXES];
   // Stage 2: per-axis products
   logic                         v2_ff;
   logic signed [PB-1:0]         far_p_ff [AXES], far_p_in [AXES];
   logic signed [PB-1:0]         near_p_ff [AXES], near_p_in [AXES];
   // Stage 3: dot products
   logic                         v3_ff;
   logic signed [OB-1:0]         far_s_ff, far_s_in;
   logic signed [OB-1:0]         near_s_ff, near_s_in;
   // Stage 4: classification
   logic                         v4_ff;
   logic [SIDE_BITS-1:0]         sides_ff, sides_in;

   // Pick far and near corners per axis from the sign mask
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         far_c_in[i]  = sign_mask[i] ? box_lo[i] : box_hi[i];
         near_c_in[i] = sign_mask[i] ? box_hi[i] : box_lo[i];
      end
   end

   // Multiply each corner coordinate by its normal component
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         far_p_in[i]  = PB'(far_c_ff[i] * normal[i]);
         near_p_in[i] = PB'(near_c_ff[i] * normal[i]);
      end
   end

   // Sum the three products at full width
   always_comb begin
      far_s_in  = '0;
      near_s_in = '0;
      for (int i = 0; i < AXES; i++) begin
         far_s_in  = far_s_in +
                     signed'({{(OB-PB){far_p_ff[i][PB-1]}}, far_p_ff[i]});
         near_s_in = near_s_in +
                     signed'({{(OB-PB){near_p_ff[i][PB-1]}}, near_p_ff[i]});
      end
   end

   // Compare both distances with the plane offset
   always_comb begin
      sides_in             = '0;
      sides_in[SIDE_FRONT] = (far_s_ff >= plane_offset);
      sides_in[SIDE_BACK]  = (near_s_ff < plane_offset);
   end

   // Advance valid bits; clear them on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      far_c_ff  <= far_c_in;
      near_c_ff <= near_c_in;
      far_p_ff  <= far_p_in;
      near_p_ff <= near_p_in;
      far_s_ff  <= far_s_in;
      near_s_ff <= near_s_in;
      sides_ff  <= sides_in;
   end

   assign out_valid = v4_ff;
   assign out_sides = sides_ff;

   // Every request moves one stage per cycle, nothing dropped or duplicated
   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff) else $error("stage 1 request lost");
   a_s2_to_s3: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> v3_ff) else $error("stage 2 request lost");
   a_s3_to_s4: assert property (@(posedge clock) disable iff (reset)
      v3_ff |=> v4_ff) else $error("stage 3 request lost");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> $past(v3_ff)) else $error("result without a request");

endmodule

FILE: design/box_plane_side_test.sv
// Each taken request passes the corner, product, sum and side registers in turn.
// Throughput: one request per cycle; busy stays low from the first edge after reset ends.
// The result path has no back pressure: rsp_valid is high for exactly one cycle.
// Reset (synchronous, active high) drops all requests in flight, holds busy high
// for its duration and loads the plane registers with their default values.
`timescale 1ns / 1ps
module box_plane_side_test #(
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic signed [COORD_BITS-1:0]                req_min_x,
   input  logic signed [COORD_BITS-1:0]                req_min_y,
   input  logic signed [COORD_BITS-1:0]                req_min_z,
   input  logic signed [COORD_BITS-1:0]                req_max_x,
   input  logic signed [COORD_BITS-1:0]                req_max_y,
   input  logic signed [COORD_BITS-1:0]                req_max_z,
   output logic                                        rsp_valid,
   output logic [bpst_pkg::SIDE_BITS-1:0]              rsp_sides,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [bpst_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [COORD_BITS+NORMAL_FRAC_BITS+3:0]      csr_data
);
   import bpst_pkg::*;

   localparam int NB = NORMAL_FRAC_BITS + 2;
   localparam int OB = COORD_BITS + NORMAL_FRAC_BITS + 4;

   logic                          busy_ff;
   logic                          req_take;
   logic signed [COORD_BITS-1:0]  box_lo [AXES];
   logic signed [COORD_BITS-1:0]  box_hi [AXES];
   logic signed [NB-1:0]          normal [AXES];
   logic signed [OB-1:0]          plane_offset;
   logic [AXES-1:0]               sign_mask;

   // Hold busy only while in reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign req_take = start & ~busy_ff;

   // Gather the box corners per axis
   assign box_lo[0] = req_min_x;
   assign box_lo[1] = req_min_y;
   assign box_lo[2] = req_min_z;
   assign box_hi[0] = req_max_x;
   assign box_hi[1] = req_max_y;
   assign box_hi[2] = req_max_z;

   bpst_csr #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .normal       (normal),
      .plane_offset (plane_offset),
      .sign_mask    (sign_mask)
   );

   bpst_dot #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_dot (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_take),
      .box_lo       (box_lo),
      .box_hi       (box_hi),
      .normal       (normal),
      .plane_offset (plane_offset),
      .sign_mask    (sign_mask),
      .out_valid    (rsp_valid),
      .out_sides    (rsp_sides)
   );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the box versus plane side test block.
`timescale 1ns / 1ps
module testbench;
   import bpst_pkg::*;

   localparam int COORD_W  = 24;
   localparam int FRAC_W   = 14;
   localparam int NORMAL_W = FRAC_W + 2;
   localparam int CSR_W    = COORD_W + FRAC_W + 4;
   localparam int LATENCY  = 4;

   // Indexes past the register map; writes there must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam logic [COORD_W-1:0]  COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [COORD_W-1:0]  COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [NORMAL_W-1:0] NORMAL_MIN = {1'b1, {(NORMAL_W-1){1'b0}}};
   localparam logic [NORMAL_W-1:0] NORMAL_MAX = {1'b0, {(NORMAL_W-1){1'b1}}};
   localparam logic [NORMAL_W-1:0] NORMAL_ONE = NORMAL_W'(1) << FRAC_W;
   localparam logic [CSR_W-1:0]    OFFSET_MIN = {1'b1, {(CSR_W-1){1'b0}}};
   localparam logic [CSR_W-1:0]    OFFSET_MAX = {1'b0, {(CSR_W-1){1'b1}}};

   typedef enum logic [1:0] {
      STEP_BOX,
      STEP_CSR,
      STEP_SETTLE
   } step_kind_type;

   typedef logic [AXES-1:0][COORD_W-1:0] corner_type;

   typedef struct packed {
      step_kind_type             kind;
      corner_type                lo;
      corner_type                hi;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_W-1:0]          data;
   } step_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   logic [COORD_W-1:0]        req_min_x = '0;
   logic [COORD_W-1:0]        req_min_y = '0;
   logic [COORD_W-1:0]        req_min_z = '0;
   logic [COORD_W-1:0]        req_max_x = '0;
   logic [COORD_W-1:0]        req_max_y = '0;
   logic [COORD_W-1:0]        req_max_z = '0;
   logic                      rsp_valid;
   logic [SIDE_BITS-1:0]      rsp_sides;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_W-1:0]          csr_data  = '0;

   // Bench copy of the plane registers
   logic signed [NORMAL_W-1:0] plane_normal [AXES];
   logic signed [CSR_W-1:0]    plane_offset;
   logic [AXES-1:0]            corner_mask;

   step_type             pending_steps [$];
   logic [SIDE_BITS-1:0] expected_sides [$];

   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   boxes_taken = 0;
   int   csr_writes = 0;
   int   mismatches = 0;
   int   front_hits = 0;
   int   back_hits = 0;
   int   straddle_hits = 0;

   box_plane_side_test dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_min_x (req_min_x),
      .req_min_y (req_min_y),
      .req_min_z (req_min_z),
      .req_max_x (req_max_x),
      .req_max_y (req_max_y),
      .req_max_z (req_max_z),
      .rsp_valid (rsp_valid),
      .rsp_sides (rsp_sides),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Classify a box against the bench copy of the plane
   function automatic logic [SIDE_BITS-1:0] classify_box(input corner_type lo,
                                                         input corner_type hi);
      longint               far_dist;
      longint               near_dist;
      longint               lo_c;
      longint               hi_c;
      longint               weight;
      longint               offset_l;
      logic [SIDE_BITS-1:0] sides;
      far_dist  = 0;
      near_dist = 0;
      sides     = '0;
      for (int a = 0; a < AXES; a++) begin
         lo_c   = $signed(lo[a]);
         hi_c   = $signed(hi[a]);
         weight = plane_normal[a];
         // a set mask bit swaps which corner is far
         if (corner_mask[a]) begin
            far_dist  += weight * lo_c;
            near_dist += weight * hi_c;
         end else begin
            far_dist  += weight * hi_c;
            near_dist += weight * lo_c;
         end
      end
      offset_l = plane_offset;
      sides[SIDE_FRONT] = (far_dist >= offset_l);
      sides[SIDE_BACK]  = (near_dist < offset_l);
      return sides;
   endfunction

   task automatic store_plane_register(input logic [CSR_INDEX_BITS-1:0] index,
                                       input logic [CSR_W-1:0] data);
      case (index)
         CSR_NORMAL_X:     plane_normal[0] = data[NORMAL_W-1:0];
         CSR_NORMAL_Y:     plane_normal[1] = data[NORMAL_W-1:0];
         CSR_NORMAL_Z:     plane_normal[2] = data[NORMAL_W-1:0];
         CSR_PLANE_OFFSET: plane_offset    = data;
         CSR_SIGN_MASK:    corner_mask     = data[AXES-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [63:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      logic [31:0]        r;
      logic [COORD_W-1:0] v;
      case ($urandom_range(3))
         0: begin
            r = $urandom;
            v = r[COORD_W-1:0];
         end
         1: begin
            r = $urandom_range(8);
            v = r[COORD_W-1:0] - COORD_W'(4);
         end
         2: begin
            case ($urandom_range(3))
               0: v = COORD_MIN;
               1: v = COORD_MAX;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: begin
            r = $urandom_range(2000);
            v = r[COORD_W-1:0] - COORD_W'(1000);
         end
      endcase
      return v;
   endfunction

   function automatic logic [NORMAL_W-1:0] pick_normal();
      logic [31:0]         r;
      logic [NORMAL_W-1:0] v;
      case ($urandom_range(3))
         0: begin
            r = $urandom;
            v = r[NORMAL_W-1:0];
         end
         1: begin
            case ($urandom_range(4))
               0: v = NORMAL_MIN;
               1: v = NORMAL_MAX;
               2: v = NORMAL_ONE;
               3: v = -NORMAL_ONE;
               default: v = '0;
            endcase
         end
         2: begin
            r = $urandom_range(6);
            v = r[NORMAL_W-1:0] - NORMAL_W'(3);
         end
         default: begin
            r = $urandom_range(2 * NORMAL_ONE);
            v = r[NORMAL_W-1:0] - NORMAL_ONE;
         end
      endcase
      return v;
   endfunction

   function automatic logic [CSR_W-1:0] pick_offset();
      logic [63:0]   r;
      longint signed s;
      logic [CSR_W-1:0] v;
      r = wide_random();
      case ($urandom_range(3))
         0: v = r[CSR_W-1:0];
         1: v = CSR_W'($urandom_range(16)) - CSR_W'(8);
         2: begin
            // random magnitude around the range of typical dot products
            s = r;
            s = s >>> (64 - $urandom_range(1, 40));
            v = s[CSR_W-1:0];
         end
         default: begin
            s = longint'($urandom_range(20)) - 10;
            s = s <<< FRAC_W;
            v = s[CSR_W-1:0];
         end
      endcase
      return v;
   endfunction

   // Queue a register write; bits above width carry noise
   task automatic queue_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_W-1:0] value, input int width);
      step_type         step;
      logic [63:0]      noise;
      logic [CSR_W-1:0] keep;
      noise = wide_random();
      keep  = (width >= CSR_W) ? '1 : ((CSR_W'(1) << width) - CSR_W'(1));
      step       = '0;
      step.kind  = STEP_CSR;
      step.index = index;
      step.data  = (noise[CSR_W-1:0] & ~keep) | (value & keep);
      pending_steps.push_back(step);
   endtask

   task automatic queue_box(input corner_type lo, input corner_type hi);
      step_type step;
      step      = '0;
      step.kind = STEP_BOX;
      step.lo   = lo;
      step.hi   = hi;
      pending_steps.push_back(step);
   endtask

   task automatic queue_settle();
      step_type step;
      step      = '0;
      step.kind = STEP_SETTLE;
      pending_steps.push_back(step);
   endtask

   function automatic corner_type make_corner(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y,
                                              input logic [COORD_W-1:0] z);
      return {z, y, x};
   endfunction

   // Mostly well-ordered boxes, some left with min above max
   task automatic queue_random_box();
      corner_type         lo;
      corner_type         hi;
      logic [COORD_W-1:0] t;
      logic               order;
      order = ($urandom_range(99) < 70);
      for (int a = 0; a < AXES; a++) begin
         lo[a] = pick_coord();
         hi[a] = pick_coord();
         if (order && $signed(lo[a]) > $signed(hi[a])) begin
            t     = lo[a];
            lo[a] = hi[a];
            hi[a] = t;
         end
      end
      queue_box(lo, hi);
   endtask

   // New plane; the mask usually follows the normal's signs
   task automatic queue_random_plane();
      logic [NORMAL_W-1:0] n [AXES];
      logic [AXES-1:0]     mask;
      for (int a = 0; a < AXES; a++) begin
         n[a]    = pick_normal();
         mask[a] = n[a][NORMAL_W-1];
      end
      if ($urandom_range(99) < 30)
         mask = AXES'($urandom_range(7));
      queue_csr(CSR_NORMAL_X, n[0], NORMAL_W);
      queue_csr(CSR_NORMAL_Y, n[1], NORMAL_W);
      queue_csr(CSR_NORMAL_Z, n[2], NORMAL_W);
      queue_csr(CSR_PLANE_OFFSET, pick_offset(), CSR_W);
      queue_csr(CSR_SIGN_MASK, mask, AXES);
      if ($urandom_range(99) < 25)
         queue_csr(CSR_SPARE_FIRST + CSR_INDEX_BITS'($urandom_range(2)), '0, 0);
   endtask

   // Drive requests and register writes at the falling edge
   always @(negedge clock) begin : drive_requests
      step_type step;
      logic     next_start;
      logic     next_csr;
      logic     calm;
      logic     gap;
      if (!reset && !((start && !req_taken) || (csr_valid && !csr_taken))) begin
         next_start = 1'b0;
         next_csr   = 1'b0;
         calm = (boxes_taken >= 500 && boxes_taken < 700);
         gap  = !calm && ($urandom_range(99) < 16);
         if (!gap && pending_steps.size() > 0) begin
            step = pending_steps[0];
            case (step.kind)
               STEP_BOX: begin
                  void'(pending_steps.pop_front());
                  req_min_x  <= step.lo[0];
                  req_min_y  <= step.lo[1];
                  req_min_z  <= step.lo[2];
                  req_max_x  <= step.hi[0];
                  req_max_y  <= step.hi[1];
                  req_max_z  <= step.hi[2];
                  next_start = 1'b1;
               end
               STEP_CSR: begin
                  // write only once the pipeline has drained
                  if (expected_sides.size() == 0) begin
                     void'(pending_steps.pop_front());
                     csr_index <= step.index;
                     csr_data  <= step.data;
                     next_csr  = 1'b1;
                  end
               end
               default: begin
                  if (expected_sides.size() == 0)
                     void'(pending_steps.pop_front());
               end
            endcase
         end
         start     <= next_start;
         csr_valid <= next_csr;
      end
   end

   // Sample handshakes, predict and check at the rising edge
   always @(posedge clock) begin : watch_results
      logic [SIDE_BITS-1:0] want;
      if (reset) begin
         req_taken       = 1'b0;
         csr_taken       = 1'b0;
         plane_normal[0] = '0;
         plane_normal[1] = '0;
         plane_normal[2] = NORMAL_ONE;
         plane_offset    = '0;
         corner_mask     = '0;
      end else begin
         req_taken = start && !busy;
         csr_taken = csr_valid && csr_ready;
         if (req_taken) begin
            expected_sides.push_back(classify_box(
               make_corner(req_min_x, req_min_y, req_min_z),
               make_corner(req_max_x, req_max_y, req_max_z)));
            boxes_taken++;
         end
         if (csr_taken) begin
            store_plane_register(csr_index, csr_data);
            csr_writes++;
         end
         if (rsp_valid) begin
            if (expected_sides.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual sides %0d",
                        $time, rsp_sides);
            end else begin
               want = expected_sides.pop_front();
               if (rsp_sides !== want) begin
                  mismatches++;
                  $display("%0t: sides expected %0d, actual %0d", $time, want, rsp_sides);
               end
               if (want[SIDE_FRONT] && want[SIDE_BACK])
                  straddle_hits++;
               else if (want[SIDE_FRONT])
                  front_hits++;
               else if (want[SIDE_BACK])
                  back_hits++;
            end
         end
      end
   end

   // Build the request list, run it, and report
   initial begin : run_plan
      int count;
      int settle_at;

      // default plane: z up through the origin
      queue_box(make_corner('0, '0, '0), make_corner('0, '0, '0));
      queue_box(make_corner(COORD_MIN, COORD_MIN, COORD_MIN),
                make_corner(COORD_MAX, COORD_MAX, COORD_MAX));
      queue_box(make_corner('0, '0, COORD_W'(100)), make_corner('0, '0, -COORD_W'(100)));
      queue_box(make_corner('0, '0, -COORD_W'(5)), make_corner('0, '0, -COORD_W'(1)));

      // widest normals, mask matching their signs
      queue_csr(CSR_NORMAL_X, NORMAL_MIN, NORMAL_W);
      queue_csr(CSR_NORMAL_Y, NORMAL_MAX, NORMAL_W);
      queue_csr(CSR_NORMAL_Z, '0, NORMAL_W);
      queue_csr(CSR_PLANE_OFFSET, '0, CSR_W);
      queue_csr(CSR_SIGN_MASK, AXES'(3'b001), AXES);
      queue_box(make_corner(COORD_MIN, COORD_MIN, COORD_MIN),
                make_corner(COORD_MAX, COORD_MAX, COORD_MAX));
      queue_box(make_corner(COORD_MAX, COORD_MAX, COORD_MAX),
                make_corner(COORD_MAX, COORD_MAX, COORD_MAX));
      queue_box(make_corner(COORD_MIN, COORD_MIN, COORD_MIN),
                make_corner(COORD_MIN, COORD_MIN, COORD_MIN));

      // mask that disagrees with the normal
      queue_csr(CSR_SIGN_MASK, AXES'(3'b110), AXES);
      queue_random_box();
      queue_random_box();
      queue_box(make_corner(COORD_MAX, COORD_MAX, COORD_MAX),
                make_corner(COORD_MIN, COORD_MIN, COORD_MIN));

      // offset extremes
      queue_csr(CSR_PLANE_OFFSET, OFFSET_MAX, CSR_W);
      queue_box(make_corner(COORD_MIN, COORD_MIN, COORD_MIN),
                make_corner(COORD_MAX, COORD_MAX, COORD_MAX));
      queue_csr(CSR_PLANE_OFFSET, OFFSET_MIN, CSR_W);
      queue_box(make_corner(COORD_MIN, COORD_MIN, COORD_MIN),
                make_corner(COORD_MAX, COORD_MAX, COORD_MAX));

      // writes past the map leave the plane alone
      queue_csr(CSR_SPARE_FIRST, '0, 0);
      queue_csr(CSR_SPARE_FIRST + CSR_INDEX_BITS'(1), '0, 0);
      queue_csr(CSR_SPARE_LAST, '0, 0);
      queue_random_box();
      queue_random_box();

      // zero normal: every box sits exactly on the plane
      queue_csr(CSR_NORMAL_X, '0, NORMAL_W);
      queue_csr(CSR_NORMAL_Y, '0, NORMAL_W);
      queue_csr(CSR_PLANE_OFFSET, '0, CSR_W);
      queue_random_box();

      // random planes, each with a batch of boxes
      for (int p = 0; p < 12; p++) begin
         queue_random_plane();
         count     = $urandom_range(80, 90);
         settle_at = $urandom_range(count - 1);
         for (int i = 0; i < count; i++) begin
            if (i == settle_at && (p % 3) == 0)
               queue_settle();
            queue_random_box();
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_steps.size() > 0 || start || csr_valid || expected_sides.size() > 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      $display("Checked %0d boxes against %0d register writes over fixed and random planes.",
               boxes_taken, csr_writes);
      $display("Outcomes: front only %0d, back only %0d, straddling %0d.",
               front_hits, back_hits, straddle_hits);
      if (mismatches == 0)
         $display("box_plane_side_test: match");
      else
         $display("box_plane_side_test: mismatch");
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #2000000;
      $display("box_plane_side_test: mismatch");
      $finish;
   end

endmodule
